[hdl/packed_bitfield_record_store_macros.svh]
// assertion macros for the packed bit-field record store checker
`ifndef PACKED_BITFIELD_RECORD_STORE_MACROS_SVH
`define PACKED_BITFIELD_RECORD_STORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PBRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PBRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pbrs_pkg.sv]
// package: types and constants of the packed bit-field record store
`timescale 1ns / 1ps

package pbrs_pkg;

    localparam int unsigned PROD_W = 27;

    localparam logic [0:0] CMD_READ  = 1'b0;
    localparam logic [0:0] CMD_WRITE = 1'b1;

    localparam logic [1:0] FIELD_0    = 2'd0;
    localparam logic [1:0] FIELD_1    = 2'd1;
    localparam logic [1:0] FIELD_2    = 2'd2;
    localparam logic [1:0] FIELD_NONE = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NEG   = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [1:0] REG_WIDTH_FIRST  = 2'd0;
    localparam logic [1:0] REG_WIDTH_SECOND = 2'd1;
    localparam logic [1:0] REG_WIDTH_THIRD  = 2'd2;
    localparam logic [1:0] REG_ENTRY_COUNT  = 2'd3;

    localparam logic [5:0]  RST_WIDTH_FIRST  = 6'd8;
    localparam logic [5:0]  RST_WIDTH_SECOND = 6'd32;
    localparam logic [5:0]  RST_WIDTH_THIRD  = 6'd24;
    localparam logic [17:0] RST_ENTRY_COUNT  = 18'd4096;

    typedef struct packed {
        logic [0:0]         cmd;
        logic [17:0]        record_index;
        logic [1:0]         field_select;
        logic signed [63:0] write_value;
    } req_t;

    typedef struct packed {
        logic [62:0] read_value;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [5:0]  width_first_field;
        logic [5:0]  width_second_field;
        logic [5:0]  width_third_field;
        logic [17:0] entry_count;
    } cfg_t;

    typedef struct packed {
        logic [5:0] shift;
        logic [5:0] width;
        logic       span;
    } geom_t;

endpackage

[hdl/pbrs_ram.sv]
// generic single-clock ram: one write port, one registered read port
`timescale 1ns / 1ps

module pbrs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pbrs_field.sv]
// field unit: extracts a field from one or two words and merges a new value in
`timescale 1ns / 1ps

module pbrs_field (
    input  pbrs_pkg::geom_t geom,
    input  logic [63:0]     data_lo,
    input  logic [63:0]     data_hi,
    input  logic [63:0]     value,
    output logic [62:0]     field,
    output logic [63:0]     merged_lo,
    output logic [63:0]     merged_hi
);

    logic [63:0] mask;
    logic [6:0]  hi_shift;
    logic [63:0] val_masked;
    logic [63:0] field_lo;
    logic [63:0] field_hi;
    logic [63:0] field_all;

    always_comb
    begin
        mask       = (64'd1 << geom.width) - 64'd1;
        hi_shift   = 7'd64 - 7'(geom.shift);
        val_masked = value & mask;
        field_lo   = (data_lo >> geom.shift) & mask;
        field_hi   = geom.span ? ((data_hi & (mask >> hi_shift)) << hi_shift) : 64'd0;
        field_all  = field_lo | field_hi;
        field      = field_all[62:0];
        merged_lo  = (data_lo & ~(mask << geom.shift)) | (val_masked << geom.shift);
        merged_hi  = (data_hi & ~(mask >> hi_shift)) | (val_masked >> hi_shift);
    end

endmodule

[hdl/pbrs_ctrl.sv]
// sequencer: clearing pass, range checks, address math and read-modify-write
`timescale 1ns / 1ps

module pbrs_ctrl #(
    parameter int unsigned WORDS = 4096
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pbrs_pkg::cfg_t           cfg,
    input  logic                     start,
    input  pbrs_pkg::req_t           request,
    output logic                     busy,
    output logic                     done,
    output pbrs_pkg::rsp_t           result,
    output logic                     ram_we,
    output logic [$clog2(WORDS)-1:0] ram_waddr,
    output logic [63:0]              ram_wdata,
    output logic [$clog2(WORDS)-1:0] ram_raddr,
    input  logic [63:0]              ram_rdata
);

    localparam int unsigned AW = $clog2(WORDS);
    localparam int unsigned PW = pbrs_pkg::PROD_W;
    localparam logic [31:0] WORDS_W    = 32'(WORDS);
    localparam logic [31:0] BITS_TOTAL = 32'(WORDS * 64);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_RD2,
        S_MOD,
        S_WR1,
        S_DONE
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   clr_cnt_reg;
    pbrs_pkg::req_t  req_reg;
    logic [PW-1:0]   prod_reg;
    logic [1:0]      status_reg;
    logic [AW-1:0]   wi_reg;
    pbrs_pkg::geom_t geom_reg;
    logic [63:0]     data_lo_reg;
    logic [63:0]     data_hi_reg;
    logic [62:0]     rd_reg;

    logic [7:0]      sum;
    logic [5:0]      width;
    logic [6:0]      off;
    logic            one_word;
    logic [1:0]      pre_status;
    logic [PW-1:0]   bit_addr;
    logic            range_bad;
    logic [5:0]      shift_sel;
    logic [AW-1:0]   wi_sel;
    logic [62:0]     field;
    logic [63:0]     merged_lo;
    logic [63:0]     merged_hi;

    always_comb
    begin
        sum = 8'(cfg.width_first_field) + 8'(cfg.width_second_field)
            + 8'(cfg.width_third_field);
        unique case (req_reg.field_select)
            pbrs_pkg::FIELD_0:
            begin
                width = cfg.width_first_field;
                off   = 7'd0;
            end
            pbrs_pkg::FIELD_1:
            begin
                width = cfg.width_second_field;
                off   = 7'(cfg.width_first_field);
            end
            pbrs_pkg::FIELD_2:
            begin
                width = cfg.width_third_field;
                off   = 7'(cfg.width_first_field) + 7'(cfg.width_second_field);
            end
            default:
            begin
                width = 6'd0;
                off   = 7'd0;
            end
        endcase
        one_word = (sum <= 8'd64);

        if (req_reg.cmd == pbrs_pkg::CMD_WRITE && req_reg.write_value[63])
        begin
            pre_status = pbrs_pkg::STAT_NEG;
        end
        else if (req_reg.field_select == pbrs_pkg::FIELD_NONE
                 || req_reg.record_index >= cfg.entry_count)
        begin
            pre_status = pbrs_pkg::STAT_RANGE;
        end
        else
        begin
            pre_status = pbrs_pkg::STAT_OK;
        end

        bit_addr  = prod_reg - PW'(sum) + PW'(off);
        range_bad = one_word ? (32'(req_reg.record_index) >= WORDS_W)
                             : (32'(prod_reg) > BITS_TOTAL);
        shift_sel = one_word ? off[5:0] : bit_addr[5:0];
        wi_sel    = one_word ? req_reg.record_index[AW-1:0] : bit_addr[AW+5:6];
    end

    pbrs_field u_field (
        .geom      (geom_reg),
        .data_lo   (data_lo_reg),
        .data_hi   (data_hi_reg),
        .value     (req_reg.write_value),
        .field     (field),
        .merged_lo (merged_lo),
        .merged_hi (merged_hi)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wi_reg;
        ram_wdata = merged_lo;
        ram_raddr = (state_reg == S_RD1) ? (wi_reg + AW'(1)) : wi_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 64'd0;
            end
            S_MOD:
            begin
                ram_we = (req_reg.cmd == pbrs_pkg::CMD_WRITE);
            end
            S_WR1:
            begin
                ram_we    = 1'b1;
                ram_waddr = wi_reg + AW'(1);
                ram_wdata = merged_hi;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            req_reg     <= '0;
            prod_reg    <= '0;
            status_reg  <= pbrs_pkg::STAT_OK;
            wi_reg      <= '0;
            geom_reg    <= '0;
            data_lo_reg <= '0;
            data_hi_reg <= '0;
            rd_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == LAST_WORD)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= request;
                        rd_reg    <= '0;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    status_reg <= pre_status;
                    prod_reg   <= (PW'(req_reg.record_index) + PW'(1)) * PW'(sum);
                    state_reg  <= S_ADDR;
                end
                S_ADDR:
                begin
                    wi_reg         <= wi_sel;
                    geom_reg.shift <= shift_sel;
                    geom_reg.width <= width;
                    geom_reg.span  <= (7'(width) + 7'(shift_sel)) > 7'd64;
                    if (status_reg != pbrs_pkg::STAT_OK)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (range_bad)
                    begin
                        status_reg <= pbrs_pkg::STAT_RANGE;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    data_lo_reg <= ram_rdata;
                    state_reg   <= S_RD2;
                end
                S_RD2:
                begin
                    data_hi_reg <= ram_rdata;
                    state_reg   <= S_MOD;
                end
                S_MOD:
                begin
                    if (req_reg.cmd == pbrs_pkg::CMD_READ)
                    begin
                        rd_reg <= field;
                    end
                    if (req_reg.cmd == pbrs_pkg::CMD_WRITE && geom_reg.span)
                    begin
                        state_reg <= S_WR1;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_WR1:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = (state_reg == S_DONE);
    assign result.read_value = rd_reg;
    assign result.status     = status_reg;

endmodule

[hdl/packed_bitfield_record_store.sv]
// top level of the packed bit-field record store
`timescale 1ns / 1ps

// Record store: WORDS 64-bit words hold records of three fields whose widths
// come from the configuration registers. Records take one word each when the
// widths sum to 64 or less, else they are packed back to back.
// Requests: drive request and pulse start; a transfer happens on a clock edge
// with start high and busy low. One request is worked on at a time.
// Results: done is high for exactly one cycle with result valid; the receiver
// must take it then, it cannot stall the block.
// Steps after acceptance: S_CALC, S_ADDR, then S_DONE for a request rejected by
// the checks, else S_RD0, S_RD1, S_RD2 (two words read through the one read
// port), S_MOD, S_WR1 for a write spanning two words, and S_DONE; busy drops
// the cycle after done. Configuration: cfg_write, cfg_index, cfg_data, written
// on any clock edge with cfg_write high; the user must write them only while
// no request is in flight, which the block itself does not enforce. Reset:
// registers return to their defaults and a clearing pass zeroes the memory one
// word a cycle; busy stays high after reset until every word has been cleared.
module packed_bitfield_record_store #(
    parameter int unsigned WORDS = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pbrs_pkg::req_t  request,
    output logic            busy,
    output logic            done,
    output pbrs_pkg::rsp_t  result,
    input  logic            cfg_write,
    input  logic [1:0]      cfg_index,
    input  logic [17:0]     cfg_data
);

    localparam int unsigned AW = $clog2(WORDS);

    pbrs_pkg::cfg_t cfg_reg;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [63:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [63:0]    ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_first_field  <= pbrs_pkg::RST_WIDTH_FIRST;
            cfg_reg.width_second_field <= pbrs_pkg::RST_WIDTH_SECOND;
            cfg_reg.width_third_field  <= pbrs_pkg::RST_WIDTH_THIRD;
            cfg_reg.entry_count        <= pbrs_pkg::RST_ENTRY_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pbrs_pkg::REG_WIDTH_FIRST:  cfg_reg.width_first_field  <= cfg_data[5:0];
                pbrs_pkg::REG_WIDTH_SECOND: cfg_reg.width_second_field <= cfg_data[5:0];
                pbrs_pkg::REG_WIDTH_THIRD:  cfg_reg.width_third_field  <= cfg_data[5:0];
                pbrs_pkg::REG_ENTRY_COUNT:  cfg_reg.entry_count        <= cfg_data;
                default:                    cfg_reg.entry_count        <= cfg_reg.entry_count;
            endcase
        end
    end

    pbrs_ctrl #(
        .WORDS (WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    pbrs_ram #(
        .WIDTH (64),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[hdl/pbrs_checker.sv]
// port-level checker for the packed bit-field record store, with its bind
`timescale 1ns / 1ps
`include "packed_bitfield_record_store_macros.svh"

module pbrs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input pbrs_pkg::rsp_t result
);

    `PBRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after a request transfer")
    `PBRS_ASSERT_NOW(a_done_busy, done, busy, "result shown while idle")
    `PBRS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `PBRS_ASSERT_NOW(a_err_zero, done && result.status != pbrs_pkg::STAT_OK,
                     result.read_value == 63'd0, "error result with nonzero value")
    `PBRS_ASSERT_NOW(a_status_code, done, result.status <= pbrs_pkg::STAT_RANGE,
                     "undefined status code")

endmodule

bind packed_bitfield_record_store pbrs_checker u_pbrs_checker (.*);
